// File: rtl/frx_pkg.sv
package frx_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_READ    = 2'd1,
        OP_ACK     = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 1'd1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] END_MARKER_RST   = 8'h55;

    // Frame layout: start, length, <length bytes>, checksum, end
    localparam int MIN_CHECK_COUNT = 5;
    localparam int LEN_OVERHEAD    = 4;

    localparam int BUFFER_DEPTH_DEF = 128;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 7;

    // Result fields known at accept time; read data joins one stage later
    typedef struct packed {
        logic              frame_ready;
        logic [BYTE_W-1:0] frame_length;
        logic              check_failed;
        logic              is_read;
    } stage_t;

endpackage

// File: rtl/frx_if.sv
interface frx_req_if;
    logic                             valid;
    logic                             ready;
    logic [frx_pkg::OP_W-1:0]         operation;
    logic [frx_pkg::BYTE_W-1:0]       rx_byte;
    logic [frx_pkg::INDEX_W-1:0]      read_index;

    modport source (output valid, output operation, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input operation, input rx_byte, input read_index,
                    output ready);
endinterface

interface frx_rsp_if;
    logic                             valid;
    logic                             ready;
    logic                             frame_ready;
    logic [frx_pkg::BYTE_W-1:0]       frame_length;
    logic                             check_failed;
    logic [frx_pkg::BYTE_W-1:0]       read_data;

    modport source (output valid, output frame_ready, output frame_length,
                    output check_failed, output read_data, input ready);
    modport sink   (input valid, input frame_ready, input frame_length,
                    input check_failed, input read_data, output ready);
endinterface

// File: rtl/frx_ram.sv
module frx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/sof_eof_frame_receiver_xor.sv
// Framed byte receiver with XOR frame check.
// rx (sink): one request per cycle while rx.ready is high. operation 0 stores rx_byte and runs the
// start/end marker logic, 1 reads the stored byte at read_index, 2 acknowledges
// the ready frame (clears ready and the write position), 3 does nothing.
// result (source): exactly one response per request, in order, giving
// frame_ready, frame_length (zero unless ready), a one-response check_failed
// flag and read_data (zero except for reads inside the buffer).
// cfg_we/cfg_index/cfg_data write the start and end markers; write only while
// no request is in flight.
// Requests pass through the holding stage and then the output register. Throughput is
// one request per cycle while result.ready is high: the buffer RAM is written and read once per
// cycle, and its registered read lines up with a one-entry holding stage ahead of the output register.
// Reset clears the markers to 0xAA/0x55 and all frame state; the buffer RAM is
// not cleared and needs no sweep. When result.ready is low, one more request
// is taken into the holding stage, then rx.ready drops until the output drains.
module sof_eof_frame_receiver_xor #(
    parameter int BUFFER_DEPTH = frx_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [frx_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [frx_pkg::CFG_DATA_W-1:0]      cfg_data,
    frx_req_if.sink                             rx,
    frx_rsp_if.source                           result
);

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int PW   = $clog2(BUFFER_DEPTH + 1);
    localparam int BW   = frx_pkg::BYTE_W;
    localparam int CMPW = 10;

    logic [BW-1:0] start_marker_reg, start_marker_next;
    logic [BW-1:0] end_marker_reg, end_marker_next;

    logic [PW-1:0] wpos_reg, wpos_next;
    logic          ready_reg, ready_next;
    logic [BW-1:0] held_len_reg, held_len_next;
    logic [BW-1:0] xor_reg, xor_next;
    logic [BW-1:0] prev_reg, prev_next;
    logic [BW-1:0] len_reg, len_next;

    logic              s1_valid_reg, s1_valid_next;
    frx_pkg::stage_t   s1_reg, s1_next;
    logic              s2_valid_reg, s2_valid_next;
    frx_pkg::stage_t   s2_reg, s2_next;
    logic [BW-1:0]     s2_data_reg, s2_data_next;

    logic          accept;
    logic          s1_adv;
    frx_pkg::op_t  op;
    logic [BW-1:0] b;
    logic          is_start;
    logic [PW-1:0] wpos_a;
    logic [BW-1:0] xor_a;
    logic          do_store;
    logic [BW-1:0] len_eff;
    logic          failed;
    logic          in_range;

    logic          ram_we;
    logic          ram_re;
    logic [BW-1:0] ram_q;

    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || result.ready);
    assign rx.ready = !s1_valid_reg || s1_adv;
    assign accept   = rx.valid && rx.ready;
    assign op       = frx_pkg::op_t'(rx.operation);
    assign b        = rx.rx_byte;
    assign in_range = 9'(rx.read_index) < 9'(BUFFER_DEPTH);

    // Receive path: marker restart, store, running XOR, end-of-frame check
    always_comb
    begin
        is_start = (b == start_marker_reg);
        wpos_a   = is_start ? '0 : wpos_reg;
        xor_a    = is_start ? '0 : xor_reg;
        do_store = wpos_a < PW'(BUFFER_DEPTH);
        len_eff  = (do_store && wpos_a == PW'(1)) ? b : len_reg;
    end

    always_comb
    begin
        wpos_next     = wpos_reg;
        ready_next    = ready_reg;
        held_len_next = held_len_reg;
        xor_next      = xor_reg;
        prev_next     = prev_reg;
        len_next      = len_reg;
        failed        = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        if (accept)
        begin
            unique case (op)
                frx_pkg::OP_RECEIVE:
                begin
                    wpos_next = wpos_a;
                    xor_next  = xor_a;
                    len_next  = len_eff;
                    if (do_store)
                    begin
                        ram_we    = 1'b1;
                        xor_next  = (wpos_a != '0) ? (xor_a ^ b) : xor_a;
                        prev_next = b;
                        wpos_next = wpos_a + PW'(1);
                    end
                    if (b == end_marker_reg && wpos_next >= PW'(frx_pkg::MIN_CHECK_COUNT))
                    begin
                        if ((CMPW'(len_eff) + CMPW'(frx_pkg::LEN_OVERHEAD) == CMPW'(wpos_next))
                            && xor_next == prev_next)
                        begin
                            ready_next    = 1'b1;
                            held_len_next = len_eff;
                        end
                        else
                        begin
                            ready_next = 1'b0;
                            failed     = 1'b1;
                        end
                    end
                end
                frx_pkg::OP_READ:
                begin
                    ram_re = in_range;
                end
                frx_pkg::OP_ACK:
                begin
                    ready_next = 1'b0;
                    wpos_next  = '0;
                    xor_next   = '0;
                end
                frx_pkg::OP_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    frx_ram #(
        .WIDTH (BW),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wpos_a[AW-1:0]),
        .wdata (b),
        .re    (ram_re),
        .raddr (AW'(rx.read_index)),
        .rdata (ram_q)
    );

    // Configuration writes
    always_comb
    begin
        start_marker_next = start_marker_reg;
        end_marker_next   = end_marker_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                frx_pkg::REG_START_MARKER: start_marker_next = cfg_data[BW-1:0];
                frx_pkg::REG_END_MARKER:   end_marker_next   = cfg_data[BW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Holding stage lines up with the RAM read; output register follows
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        s2_valid_next = s2_valid_reg;
        s2_next       = s2_reg;
        s2_data_next  = s2_data_reg;

        if (result.ready)
        begin
            s2_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            s2_valid_next = 1'b1;
            s2_next       = s1_reg;
            s2_data_next  = s1_reg.is_read ? ram_q : '0;
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next        = 1'b1;
            s1_next.frame_ready  = ready_next;
            s1_next.frame_length = ready_next ? held_len_next : '0;
            s1_next.check_failed = failed;
            s1_next.is_read      = (op == frx_pkg::OP_READ) && in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= frx_pkg::START_MARKER_RST;
            end_marker_reg   <= frx_pkg::END_MARKER_RST;
            wpos_reg         <= '0;
            ready_reg        <= 1'b0;
            held_len_reg     <= '0;
            xor_reg          <= '0;
            prev_reg         <= '0;
            len_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
        end
        else
        begin
            start_marker_reg <= start_marker_next;
            end_marker_reg   <= end_marker_next;
            wpos_reg         <= wpos_next;
            ready_reg        <= ready_next;
            held_len_reg     <= held_len_next;
            xor_reg          <= xor_next;
            prev_reg         <= prev_next;
            len_reg          <= len_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        s2_data_reg <= s2_data_next;
    end

    assign result.valid        = s2_valid_reg;
    assign result.frame_ready  = s2_reg.frame_ready;
    assign result.frame_length = s2_reg.frame_length;
    assign result.check_failed = s2_reg.check_failed;
    assign result.read_data    = s2_data_reg;

endmodule
